// File: design/dhoat_pkg.sv
// Shared constants, types and helper function of the double-hash table.
package dhoat_pkg;

  localparam int MAX_SLOTS    = 1024;
  localparam int SLOT_W       = $clog2(MAX_SLOTS);
  localparam int CNT_W        = $clog2(MAX_SLOTS + 1);
  localparam int PAYLOAD_BITS = 32;
  localparam int REQ_W        = 2;
  localparam int CODE_W       = 24;
  localparam int DAY_W        = 5;
  localparam int MON_W        = 4;
  localparam int YEAR_W       = 14;
  localparam int KEY_W        = CODE_W + YEAR_W + MON_W + DAY_W;
  localparam int ENTRY_W      = 1 + KEY_W + PAYLOAD_BITS;
  localparam int HASH_W       = 64;
  localparam int STAT_W       = 3;
  localparam int SEP_W        = 8;
  localparam int CFG_W        = 11;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_STORED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd4;

  localparam logic CFG_SLOTS = 1'b0;
  localparam logic CFG_SEP   = 1'b1;

  typedef struct packed {
    logic              latch;
    logic              dig_step;
    logic              dig_year;
    logic              dig_load_code;
    logic [2:0]        dig_pos;
    logic              mix_step;
    logic [4:0]        mix_pos;
    logic              mod_step;
    logic [6:0]        mod_bit;
    logic              rd;
    logic              chk;
    logic              clr_wr;
    logic [SLOT_W-1:0] clr_addr;
    logic              load_out;
  } dhoat_cmd_t;

  typedef struct packed {
    logic dig_done;
    logic mix_last;
    logic hit;
    logic last;
    logic out_free;
  } dhoat_stat_t;

  // Splits a value below 32 into its tens and ones digits.
  function automatic logic [7:0] two_digits(input logic [4:0] v);
    logic [7:0] r;
    if (v >= 5'd30) begin
      r = {4'd3, 4'(v - 5'd30)};
    end else if (v >= 5'd20) begin
      r = {4'd2, 4'(v - 5'd20)};
    end else if (v >= 5'd10) begin
      r = {4'd1, 4'(v - 5'd10)};
    end else begin
      r = {4'd0, v[3:0]};
    end
    return r;
  endfunction

endpackage

// File: design/dhoat_if.sv
// Request and response channel interfaces of the double-hash table.
interface dhoat_req_if;
  logic                                valid;
  logic                                ready;
  logic [dhoat_pkg::REQ_W-1:0]         req_type;
  logic [dhoat_pkg::CODE_W-1:0]        city_code;
  logic [dhoat_pkg::DAY_W-1:0]         date_day;
  logic [dhoat_pkg::MON_W-1:0]         date_month;
  logic [dhoat_pkg::YEAR_W-1:0]        date_year;
  logic [dhoat_pkg::PAYLOAD_BITS-1:0]  record_payload;
  modport source (output valid, req_type, city_code, date_day, date_month, date_year,
                  record_payload, input ready);
  modport sink (input valid, req_type, city_code, date_day, date_month, date_year,
                record_payload, output ready);
endinterface

interface dhoat_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [dhoat_pkg::STAT_W-1:0]        status;
  logic [dhoat_pkg::SLOT_W-1:0]        slot_index;
  logic [dhoat_pkg::CNT_W-1:0]         probe_count;
  logic [dhoat_pkg::PAYLOAD_BITS-1:0]  found_payload;
  modport source (output valid, status, slot_index, probe_count, found_payload,
                  input ready);
  modport sink (input valid, status, slot_index, probe_count, found_payload,
                output ready);
endinterface

// File: design/dhoat_ctrl.sv
// Controller state machine that sequences clearing, key formation, hashing, reduction and probing.
module dhoat_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  input  logic [dhoat_pkg::REQ_W-1:0] req_type_i,
  input  dhoat_pkg::dhoat_stat_t  stat_i,
  output logic                    req_ready_o,
  output dhoat_pkg::dhoat_cmd_t   cmd_o
);
  import dhoat_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_YDIG = 4'd2;
  localparam logic [3:0] S_CDIG = 4'd3;
  localparam logic [3:0] S_MIX  = 4'd4;
  localparam logic [3:0] S_MOD  = 4'd5;
  localparam logic [3:0] S_PRD  = 4'd6;
  localparam logic [3:0] S_PCHK = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             clr_req_q, clr_req_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_req_d   = clr_req_q;
    req_ready_o = 1'b0;
    cmd_o          = '0;
    cmd_o.dig_pos  = cnt_q[2:0];
    cmd_o.mix_pos  = cnt_q[4:0];
    cmd_o.mod_bit  = cnt_q[6:0];
    cmd_o.clr_addr = cnt_q[SLOT_W-1:0];
    case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MAX_SLOTS - 1)) begin
          state_d   = clr_req_q ? S_DONE : S_IDLE;
          clr_req_d = 1'b0;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        cnt_d = '0;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          case (req_type_i)
            REQ_INSERT, REQ_FIND: state_d = S_YDIG;
            REQ_CLEAR: begin
              state_d   = S_CLR;
              clr_req_d = 1'b1;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_YDIG: begin
        cmd_o.dig_step = 1'b1;
        cmd_o.dig_year = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(3)) begin
          cmd_o.dig_load_code = 1'b1;
          cnt_d   = '0;
          state_d = S_CDIG;
        end
      end
      S_CDIG: begin
        cmd_o.dig_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (stat_i.dig_done) begin
          cnt_d   = '0;
          state_d = S_MIX;
        end
      end
      S_MIX: begin
        cmd_o.mix_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (stat_i.mix_last) begin
          cnt_d   = CNT_W'(HASH_W);
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_PCHK;
      end
      S_PCHK: begin
        cmd_o.chk = 1'b1;
        state_d = (stat_i.hit || stat_i.last) ? S_DONE : S_PRD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      cnt_q     <= '0;
      clr_req_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      clr_req_q <= clr_req_d;
    end
  end

endmodule

// File: design/dhoat_dp.sv
// Datapath with key digits, both hashes, the modulo unit, the probe walker and the slot memory.
module dhoat_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [dhoat_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic [dhoat_pkg::REQ_W-1:0]        req_type_i,
  input  logic [dhoat_pkg::CODE_W-1:0]       city_code_i,
  input  logic [dhoat_pkg::DAY_W-1:0]        date_day_i,
  input  logic [dhoat_pkg::MON_W-1:0]        date_month_i,
  input  logic [dhoat_pkg::YEAR_W-1:0]       date_year_i,
  input  logic [dhoat_pkg::PAYLOAD_BITS-1:0] record_payload_i,
  input  dhoat_pkg::dhoat_cmd_t              cmd_i,
  output dhoat_pkg::dhoat_stat_t             stat_o,
  input  logic                               rsp_ready_i,
  output logic                               rsp_valid_o,
  output logic [dhoat_pkg::STAT_W-1:0]       status_o,
  output logic [dhoat_pkg::SLOT_W-1:0]       slot_index_o,
  output logic [dhoat_pkg::CNT_W-1:0]        probe_count_o,
  output logic [dhoat_pkg::PAYLOAD_BITS-1:0] found_payload_o
);
  import dhoat_pkg::*;

  logic [CFG_W-1:0]        slots_q;
  logic [SEP_W-1:0]        sep_q;
  logic [REQ_W-1:0]        req_q;
  logic [KEY_W-1:0]        key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [CODE_W-1:0]       dv_q;
  logic [3:0]              yd_q [4];
  logic [3:0]              cd_q [8];
  logic [3:0]              nd_q;
  logic [HASH_W-1:0]       h1_q, h2_q;
  logic [SLOT_W-1:0]       r1_q, r2_q, r3_q;
  logic [CNT_W-1:0]        pc_q;
  logic [ENTRY_W-1:0]      mem_q [MAX_SLOTS];
  logic [ENTRY_W-1:0]      rd_q;
  logic [STAT_W-1:0]       res_status_q;
  logic [SLOT_W-1:0]       res_slot_q;
  logic [PAYLOAD_BITS-1:0] res_pay_q;
  logic                    out_valid_q;

  logic [CNT_W-1:0]        n;
  logic [2*CODE_W-1:0]     prod;
  logic [CODE_W-1:0]       quo, digit_full;
  logic [7:0]              dd, md, ch;
  logic [4:0]              cd_sel;
  logic [DAY_W-1:0]        day;
  logic [MON_W-1:0]        mon;
  logic [YEAR_W-1:0]       year_lo;
  logic [SLOT_W-1:0]       m1, m2, m3;
  logic                    b1, b2, b3;
  logic [HASH_W:0]         vsum;
  logic [CNT_W-1:0]        s0, s1, s2;
  logic                    ins, hit;

  function automatic logic [SLOT_W-1:0] mod_bit_step(input logic [SLOT_W-1:0] r,
                                                     input logic b,
                                                     input logic [CNT_W-1:0] m);
    logic [CNT_W-1:0] t;
    t = {r, b};
    if (t >= m) begin
      t = t - m;
    end
    return t[SLOT_W-1:0];
  endfunction

  assign day  = key_q[DAY_W-1:0];
  assign mon  = key_q[DAY_W +: MON_W];

  always_comb begin
    if (slots_q == '0) begin
      n = CNT_W'(1);
    end else if (slots_q > CFG_W'(MAX_SLOTS)) begin
      n = CNT_W'(MAX_SLOTS);
    end else begin
      n = slots_q;
    end
  end

  assign year_lo    = (date_year_i >= YEAR_W'(10000)) ? date_year_i - YEAR_W'(10000)
                                                        : date_year_i;
  assign prod       = {{CODE_W{1'b0}}, dv_q} * {{CODE_W{1'b0}}, 24'd13421773};
  assign quo        = CODE_W'(prod[2*CODE_W-1:27]);
  assign digit_full = dv_q - ((quo << 3) + (quo << 1));

  always_comb begin
    dd     = two_digits(day);
    md     = two_digits({1'b0, mon});
    cd_sel = {1'b0, nd_q} + 5'd9 - cmd_i.mix_pos;
    case (cmd_i.mix_pos)
      5'd0: ch = {4'h3, dd[7:4]};
      5'd1: ch = {4'h3, dd[3:0]};
      5'd2: ch = sep_q;
      5'd3: ch = {4'h3, md[7:4]};
      5'd4: ch = {4'h3, md[3:0]};
      5'd5: ch = sep_q;
      5'd6: ch = {4'h3, yd_q[3]};
      5'd7: ch = {4'h3, yd_q[2]};
      5'd8: ch = {4'h3, yd_q[1]};
      5'd9: ch = {4'h3, yd_q[0]};
      default: ch = {4'h3, cd_q[cd_sel[2:0]]};
    endcase
  end

  always_comb begin
    b1 = (cmd_i.mod_bit == 7'd64) ? 1'b0 : h1_q[cmd_i.mod_bit[5:0]];
    b2 = (cmd_i.mod_bit == 7'd64) ? 1'b0 : h2_q[cmd_i.mod_bit[5:0]];
    b3 = (cmd_i.mod_bit == 7'd64);
    m1 = mod_bit_step(r1_q, b1, n);
    m2 = mod_bit_step(r2_q, b2, n);
    m3 = mod_bit_step(r3_q, b3, n);
  end

  // The next probe adds h2 to the 64-bit index; a carry out removes 2^64 mod n.
  always_comb begin
    vsum = {1'b0, h1_q} + {1'b0, h2_q};
    s0   = {1'b0, r1_q} + {1'b0, r2_q};
    s1   = (s0 >= n) ? s0 - n : s0;
    if (!vsum[HASH_W]) begin
      s2 = s1;
    end else if (s1 >= {1'b0, r3_q}) begin
      s2 = s1 - {1'b0, r3_q};
    end else begin
      s2 = s1 + n - {1'b0, r3_q};
    end
  end

  assign ins = (req_q == REQ_INSERT);
  assign hit = ins ? !rd_q[ENTRY_W-1]
                   : (rd_q[ENTRY_W-1] && (rd_q[ENTRY_W-2 -: KEY_W] == key_q));

  assign stat_o.dig_done = (quo == '0);
  assign stat_o.mix_last = (cmd_i.mix_pos == ({1'b0, nd_q} + 5'd9));
  assign stat_o.hit      = hit;
  assign stat_o.last     = (pc_q == n - 1'b1);
  assign stat_o.out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= CFG_W'(MAX_SLOTS);
      sep_q       <= 8'd47;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLOTS: slots_q <= cfg_wdata_i;
          CFG_SEP:   sep_q   <= cfg_wdata_i[SEP_W-1:0];
          default:   slots_q <= slots_q;
        endcase
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= req_type_i;
      key_q  <= {city_code_i, date_year_i, date_month_i, date_day_i};
      pay_q  <= record_payload_i;
      dv_q   <= CODE_W'(year_lo);
      h1_q   <= HASH_W'(5381);
      h2_q   <= '0;
      r1_q   <= '0;
      r2_q   <= '0;
      r3_q   <= '0;
      pc_q   <= '0;
      res_slot_q <= '0;
      res_pay_q  <= '0;
      case (req_type_i)
        REQ_INSERT: res_status_q <= ST_FULL;
        REQ_CLEAR:  res_status_q <= ST_CLEARED;
        default:    res_status_q <= ST_NOT_FOUND;
      endcase
    end
    if (cmd_i.dig_step) begin
      dv_q <= cmd_i.dig_load_code ? key_q[KEY_W-1 -: CODE_W] : quo;
      if (cmd_i.dig_year) begin
        yd_q[cmd_i.dig_pos[1:0]] <= digit_full[3:0];
      end else begin
        cd_q[cmd_i.dig_pos] <= digit_full[3:0];
        nd_q <= {1'b0, cmd_i.dig_pos} + 4'd1;
      end
    end
    if (cmd_i.mix_step) begin
      h1_q <= (h1_q << 5) + h1_q + HASH_W'(ch);
      h2_q <= HASH_W'(ch) + (h2_q << 6) + (h2_q << 16) - h2_q;
    end
    if (cmd_i.mod_step) begin
      r1_q <= m1;
      r2_q <= m2;
      r3_q <= m3;
    end
    if (cmd_i.chk) begin
      pc_q <= pc_q + 1'b1;
      if (hit) begin
        res_status_q <= ins ? ST_STORED : ST_FOUND;
        res_slot_q   <= r1_q;
        res_pay_q    <= ins ? '0 : rd_q[PAYLOAD_BITS-1:0];
      end else begin
        h1_q <= vsum[HASH_W-1:0];
        r1_q <= s2[SLOT_W-1:0];
      end
    end
    if (cmd_i.load_out) begin
      status_o        <= res_status_q;
      slot_index_o    <= res_slot_q;
      probe_count_o   <= pc_q;
      found_payload_o <= res_pay_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem_q[cmd_i.clr_addr] <= '0;
    end else if (cmd_i.chk && hit && ins) begin
      mem_q[r1_q] <= {1'b1, key_q, pay_q};
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[r1_q];
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

// File: design/double_hash_open_address_table.sv
// Top level of the double-hash open-addressed table.
// Insert or find: the year and the city code's D decimal digits (1 to 8) are split out, both
// hashes are mixed, the bit-serial modulo unit reduces them and P probes are made.
// Clear: one slot-memory write per slot. Other request codes go straight to the result.
// One item is in work at a time; a finished result waits in the output register.
// After reset a clearing pass over all 1024 slots runs with ready low; configuration writes go on.
module double_hash_open_address_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [dhoat_pkg::CFG_W-1:0] cfg_wdata_i,
  dhoat_req_if.sink                   req,
  dhoat_rsp_if.source                 rsp
);
  import dhoat_pkg::*;

  dhoat_cmd_t  cmd;
  dhoat_stat_t stat;

  dhoat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_type_i  (req.req_type),
    .stat_i      (stat),
    .req_ready_o (req.ready),
    .cmd_o       (cmd)
  );

  dhoat_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (req.req_type),
    .city_code_i      (req.city_code),
    .date_day_i       (req.date_day),
    .date_month_i     (req.date_month),
    .date_year_i      (req.date_year),
    .record_payload_i (req.record_payload),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .rsp_ready_i      (rsp.ready),
    .rsp_valid_o      (rsp.valid),
    .status_o         (rsp.status),
    .slot_index_o     (rsp.slot_index),
    .probe_count_o    (rsp.probe_count),
    .found_payload_o  (rsp.found_payload)
  );

  a_clr_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !req.ready) else $error("item taken during clearing pass");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> rsp.valid) else $error("result load lost");

  a_read_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd |=> cmd.chk) else $error("slot read not followed by check");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!rsp.valid || rsp.ready)) else $error("result overwritten");

endmodule
